/* rtl/mbpc_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package mbpc_pkg;

  // Widths fixed by the word formats.
  localparam int unsigned NOW_W     = 32;
  localparam int unsigned PIN_W     = 3;
  localparam int unsigned CODE_W    = 2;
  localparam int unsigned CFG_W     = 16;
  localparam int unsigned CFG_IDX_W = 2;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS = 2'd1;

  // Stored press classification codes.
  localparam logic [CODE_W-1:0] CODE_NONE  = 2'd0;
  localparam logic [CODE_W-1:0] CODE_SHORT = 2'd1;
  localparam logic [CODE_W-1:0] CODE_LONG  = 2'd2;

  // One poll word.
  typedef struct packed {
    logic [NOW_W-1:0] now_ms;
    logic [PIN_W-1:0] pin_levels;
  } in_word_t;

  // One result word.
  typedef struct packed {
    logic              all_released;
    logic [CODE_W-1:0] press_code_0;
    logic [CODE_W-1:0] press_code_1;
    logic [CODE_W-1:0] press_code_2;
  } out_word_t;

  // Control from the top level to one button cell.
  typedef struct packed {
    logic step;
    logic clear;
  } btn_ctl_t;

  // Status from one button cell for the poll being processed.
  typedef struct packed {
    logic              held;
    logic [CODE_W-1:0] code;
  } btn_stat_t;

endpackage

`default_nettype wire

/* rtl/multi_button_press_classifier.sv */
`timescale 1ns / 1ps
`default_nettype none

// A poll word is taken into the input register and moves on to the result
// register when that is free (one input register, one result register).
// Throughput: one poll word per cycle unless out_stall holds the output; the
// button update is two subtracts and two compares per button in between.
// Reset: synchronous active-low; clears all button state, loads the register
// defaults (debounce 50 ms, long press 1000 ms) and empties both registers.
module multi_button_press_classifier import mbpc_pkg::*; #(
  parameter int unsigned NUM_BUTTONS = 3,
  parameter int unsigned TIME_BITS   = 32
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire in_word_t             in_data,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output out_word_t                 out_data,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data
);

  localparam int unsigned PAD_N = (NUM_BUTTONS > 3) ? NUM_BUTTONS : 3;

  logic [CFG_W-1:0] debounce_r;
  logic [CFG_W-1:0] long_press_r;
  logic             in_vld_r, in_vld_nxt;
  in_word_t         in_word_r;
  logic             out_vld_r, out_vld_nxt;
  out_word_t        out_word_r, out_word_nxt;
  logic             in_take;
  logic             advance;
  logic             some_down;
  btn_ctl_t         ctl;
  btn_stat_t        stat [PAD_N];
  logic [NUM_BUTTONS-1:0] held_vec;

  // Configuration registers; the port is always ready.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_r   <= CFG_W'(50);
      long_press_r <= CFG_W'(1000);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_DEBOUNCE:   debounce_r   <= cfg_data;
        REG_LONG_PRESS: long_press_r <= cfg_data;
        default:        ;
      endcase
    end
  end

  // Handshake: the input word moves on when the result register is free.
  assign advance  = in_vld_r && (!out_vld_r || !out_stall);
  assign in_stall = in_vld_r && !advance;
  assign in_take  = in_valid && !in_stall;

  assign in_vld_nxt  = in_take ? 1'b1 : (advance ? 1'b0 : in_vld_r);
  assign out_vld_nxt = advance ? 1'b1 : (out_stall ? out_vld_r : 1'b0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      in_vld_r  <= in_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_word_r <= in_data;
    end
    if (advance) begin
      out_word_r <= out_word_nxt;
    end
  end

  // Button cells; buttons past the pin field read as held.
  assign ctl.step  = advance;
  assign ctl.clear = !some_down;

  for (genvar b = 0; b < PAD_N; b++) begin : g_btn
    if (b < NUM_BUTTONS) begin : g_cell
      logic pressed;
      if (b < PIN_W) begin : g_pin
        assign pressed = !in_word_r.pin_levels[b];
      end else begin : g_nopin
        assign pressed = 1'b1;
      end
      mbpc_button #(
        .TIME_BITS(TIME_BITS)
      ) u_button (
        .clk          (clk),
        .rst_n        (rst_n),
        .now          (in_word_r.now_ms[TIME_BITS-1:0]),
        .pressed      (pressed),
        .debounce_ms  (debounce_r),
        .long_press_ms(long_press_r),
        .ctl          (ctl),
        .stat         (stat[b])
      );
      assign held_vec[b] = stat[b].held;
    end else begin : g_none
      assign stat[b] = '{held: 1'b0, code: CODE_NONE};
    end
  end

  assign some_down = |held_vec;

  // Result word: codes are reported only when every button is released.
  always_comb begin
    out_word_nxt.all_released = !some_down;
    out_word_nxt.press_code_0 = some_down ? CODE_NONE : stat[0].code;
    out_word_nxt.press_code_1 = some_down ? CODE_NONE : stat[1].code;
    out_word_nxt.press_code_2 = some_down ? CODE_NONE : stat[2].code;
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_word_r;

  // A word that reports a held button carries no press codes.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.all_released |->
      out_data.press_code_0 == CODE_NONE && out_data.press_code_1 == CODE_NONE &&
      out_data.press_code_2 == CODE_NONE)
    else $error("press codes reported while a button is held");

  // The input side only stalls while the input register is occupied.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> in_vld_r)
    else $error("input stalled with an empty input register");

  // No classification code ever goes past the long code.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.press_code_0 <= CODE_LONG &&
      out_data.press_code_1 <= CODE_LONG && out_data.press_code_2 <= CODE_LONG)
    else $error("invalid press code");

  // A word leaving the input register always lands in the result register.
  assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_valid)
    else $error("advanced word lost");

endmodule

`default_nettype wire

/* rtl/mbpc_button.sv */
`timescale 1ns / 1ps
`default_nettype none

module mbpc_button import mbpc_pkg::*; #(
  parameter int unsigned TIME_BITS = 32
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic [TIME_BITS-1:0] now,
  input  wire logic                 pressed,
  input  wire logic [CFG_W-1:0]     debounce_ms,
  input  wire logic [CFG_W-1:0]     long_press_ms,
  input  wire btn_ctl_t             ctl,
  output btn_stat_t                 stat
);

  logic                 held_r, held_nxt;
  logic                 long_r, long_nxt;
  logic [TIME_BITS-1:0] start_r, start_nxt;
  logic [TIME_BITS-1:0] edge_r, edge_nxt;
  logic [CODE_W-1:0]    stored_r, stored_nxt, code_upd;
  logic [TIME_BITS-1:0] since_edge;
  logic [TIME_BITS-1:0] since_start;
  logic                 in_window;
  logic                 long_hit;

  // Elapsed times wrap at the time width.
  assign since_edge  = now - edge_r;
  assign since_start = now - start_r;
  assign in_window   = since_edge < TIME_BITS'(debounce_ms);
  assign long_hit    = since_start >= TIME_BITS'(long_press_ms);

  // A release outside the debounce window classifies the press.
  assign code_upd = (!in_window && !pressed && held_r)
                    ? (long_r ? CODE_LONG : CODE_SHORT) : stored_r;

  // Inside the window the held flag stands; otherwise the pin decides.
  assign stat.held = in_window ? held_r : pressed;
  assign stat.code = code_upd;

  // Next state for one poll.
  always_comb begin
    held_nxt   = held_r;
    long_nxt   = long_r;
    start_nxt  = start_r;
    edge_nxt   = edge_r;
    stored_nxt = stored_r;
    if (ctl.step) begin
      stored_nxt = ctl.clear ? CODE_NONE : code_upd;
      if (!in_window) begin
        if (pressed) begin
          if (!held_r) begin
            held_nxt  = 1'b1;
            long_nxt  = 1'b0;
            start_nxt = now;
            edge_nxt  = now;
          end else if (!long_r && long_hit) begin
            long_nxt = 1'b1;
          end
        end else if (held_r) begin
          held_nxt = 1'b0;
          edge_nxt = now;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r   <= 1'b0;
      long_r   <= 1'b0;
      start_r  <= '0;
      edge_r   <= '0;
      stored_r <= CODE_NONE;
    end else begin
      held_r   <= held_nxt;
      long_r   <= long_nxt;
      start_r  <= start_nxt;
      edge_r   <= edge_nxt;
      stored_r <= stored_nxt;
    end
  end

endmodule

`default_nettype wire
